[hdl/npst_pkg.sv]
// ----------------------------------------------------------------------------
// npst_pkg
// Shared types, metric codes and helpers for the note phrase statistics core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npst_pkg;

    // One stored note, as held in the note memory
    typedef struct packed {
        logic [23:0] start;
        logic [23:0] dur;
        logic [6:0]  pitch;
        logic [6:0]  vel;
    } t_note;

    localparam int NOTE_W = $bits(t_note);

    // Divider operand widths
    localparam int NUM_W = 48;
    localparam int DEN_W = 24;
    localparam int DCNT_W = $clog2(NUM_W);

    // Configuration register indexes
    localparam logic CFG_PHRASE_LEN = 1'b0;
    localparam logic CFG_SCALE_MASK = 1'b1;

    // Metric codes
    localparam logic [4:0] M_COUNT   = 5'd0;
    localparam logic [4:0] M_LOW     = 5'd1;
    localparam logic [4:0] M_HIGH    = 5'd2;
    localparam logic [4:0] M_MONO    = 5'd3;
    localparam logic [4:0] M_INSCALE = 5'd4;
    localparam logic [4:0] M_PROFILE = 5'd5;
    localparam logic [4:0] M_STEP    = 5'd6;
    localparam logic [4:0] M_LEAP    = 5'd7;
    localparam logic [4:0] M_REPEAT  = 5'd8;
    localparam logic [4:0] M_UP      = 5'd9;
    localparam logic [4:0] M_DOWN    = 5'd10;
    localparam logic [4:0] M_STAT    = 5'd11;
    localparam logic [4:0] M_AVG_P   = 5'd12;
    localparam logic [4:0] M_AVG_D   = 5'd13;
    localparam logic [4:0] M_AVG_V   = 5'd14;
    localparam logic [4:0] M_DENSITY = 5'd15;
    localparam logic [4:0] M_POS     = 5'd16;

    // Melodic profile codes
    localparam logic [2:0] P_STATIONARY = 3'd0;
    localparam logic [2:0] P_ASCENDING  = 3'd1;
    localparam logic [2:0] P_DESCENDING = 3'd2;
    localparam logic [2:0] P_ARCH       = 3'd3;
    localparam logic [2:0] P_VALLEY     = 3'd4;
    localparam logic [2:0] P_MIXED      = 3'd5;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SC_RD,
        S_SC_ACC,
        S_MET,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic ins_read;
        logic shift;
        logic place;
        logic acc;
        logic div_start;
        logic out_load;
        logic metric_inc;
        logic clear;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic key_gt;
        logic last;
        logic idx_last;
        logic metric_div;
        logic metric_last;
        logic div_busy;
        logic out_valid;
        logic out_fire;
    } t_sts;

    // Pitch class: pitch mod 12 through a reciprocal multiply (exact below 128)
    function automatic logic [3:0] pitch_class(input logic [6:0] p);
        logic [12:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 13'(p) * 13'd43;
        q = prod[12:9];
        r = p - 7'(q) * 7'd12;
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

[hdl/npst_ram.sv]
// ----------------------------------------------------------------------------
// npst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/npst_div.sv]
// ----------------------------------------------------------------------------
// npst_div
// Bit-serial restoring divider with round-half-up and 32-bit saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npst_div import npst_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [NUM_W-1:0]  i_num,
    input  wire [DEN_W-1:0]  i_den,
    output logic             o_busy,
    output logic [31:0]      o_quot
);

    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic [DEN_W:0]    w_t;
    logic              w_ge;

    assign w_t  = {r_rem, r_q[NUM_W-1]};
    assign w_ge = w_t >= {1'b0, r_den};

    // Control: run one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_den != '0);
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: add half the divisor, then shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= (i_den == '0) ? '0 : i_num + NUM_W'(i_den >> 1);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_t - {1'b0, r_den}) : w_t[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = (|r_q[NUM_W-1:32]) ? 32'hFFFF_FFFF : r_q[31:0];

endmodule

`default_nettype wire

[hdl/npst_dp.sv]
// ----------------------------------------------------------------------------
// npst_dp
// Datapath: note memory, sorted insertion, statistics scan, metric results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npst_dp import npst_pkg::*; #(
    parameter int MAX_NOTES = 256
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    input  wire [23:0]   i_start_beat,
    input  wire [23:0]   i_duration,
    input  wire [6:0]    i_pitch,
    input  wire [6:0]    i_velocity,
    input  wire          i_last_note,
    input  wire [23:0]   i_phrase_len,
    input  wire [11:0]   i_scale_mask,
    input  wire          i_out_stall,
    output logic         o_out_valid,
    output logic [4:0]   o_metric,
    output logic [31:0]  o_value,
    output logic         o_overflow,
    output logic         o_last_metric
);

    localparam int CW = $clog2(MAX_NOTES + 1);
    localparam int AW = $clog2(MAX_NOTES);

    logic [CW-1:0]     r_count;
    logic              r_drop;
    t_note             r_new;
    logic              r_last;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     r_idx;
    logic [4:0]        r_metric;

    t_note             r_prev;
    logic [6:0]        r_lo, r_hi;
    logic [CW+6:0]     r_sum_p, r_sum_v;
    logic [CW+23:0]    r_sum_d;
    logic              r_mono, r_insc, r_fhr, r_fhf, r_shf, r_shr;
    logic [CW-1:0]     r_steps, r_leaps, r_reps, r_ups, r_downs, r_stats;

    logic              r_out_valid;

    t_note             w_rd;
    logic [NOTE_W-1:0] w_rd_bits;
    logic [AW-1:0]     w_raddr;
    logic              w_we;
    logic [NOTE_W-1:0] w_wdata;
    logic              w_first, w_up, w_dn, w_eq, w_half, w_overlap, w_inpc;
    logic [6:0]        w_diff;
    logic [CW-1:0]     w_trans;
    logic [2:0]        w_profile;
    logic [NUM_W-1:0]  w_num;
    logic [DEN_W-1:0]  w_den;
    logic [CW+6:0]     w_lo_sum;
    logic [31:0]       w_quot;
    logic              w_div_busy;
    logic [31:0]       w_plain;
    logic              w_fire;

    // Note memory
    assign w_raddr = i_cmd.ins_read ? r_pos - AW'(1) : r_idx;
    assign w_we    = i_cmd.shift | i_cmd.place;
    assign w_wdata = i_cmd.shift ? w_rd_bits : r_new;

    npst_ram #(.WIDTH(NOTE_W), .DEPTH(MAX_NOTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_bits)
    );
    assign w_rd = t_note'(w_rd_bits);

    // Control counters and phrase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_last  <= 1'b0;
            r_pos   <= '0;
            r_idx   <= '0;
            r_metric <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_last   <= i_last_note;
                r_pos    <= r_count[AW-1:0];
                r_idx    <= '0;
                r_metric <= '0;
                if (r_count == CW'(MAX_NOTES)) begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.shift) begin
                r_pos <= r_pos - AW'(1);
            end
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.acc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.metric_inc) begin
                r_metric <= r_metric + 5'd1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    // Capture the incoming note
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new <= '{start: i_start_beat, dur: i_duration,
                       pitch: i_pitch, vel: i_velocity};
        end
    end

    // Per-note comparisons against the previous sorted note
    assign w_first   = (r_idx == '0);
    assign w_up      = w_rd.pitch > r_prev.pitch;
    assign w_dn      = w_rd.pitch < r_prev.pitch;
    assign w_eq      = w_rd.pitch == r_prev.pitch;
    assign w_diff    = w_up ? w_rd.pitch - r_prev.pitch : r_prev.pitch - w_rd.pitch;
    assign w_half    = CW'(r_idx) <= (r_count >> 1);
    assign w_overlap = {1'b0, w_rd.start} < ({1'b0, r_prev.start} + {1'b0, r_prev.dur});
    assign w_inpc    = i_scale_mask[pitch_class(w_rd.pitch)];

    // Accumulate statistics, one note per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_prev <= w_rd;
            if (w_first) begin
                r_lo    <= w_rd.pitch;
                r_hi    <= w_rd.pitch;
                r_sum_p <= (CW+7)'(w_rd.pitch);
                r_sum_d <= (CW+24)'(w_rd.dur);
                r_sum_v <= (CW+7)'(w_rd.vel);
                r_insc  <= (i_scale_mask != '0) & w_inpc;
                r_mono  <= 1'b1;
                r_fhr   <= 1'b1;
                r_fhf   <= 1'b1;
                r_shf   <= 1'b1;
                r_shr   <= 1'b1;
                r_steps <= '0;
                r_leaps <= '0;
                r_reps  <= '0;
                r_ups   <= '0;
                r_downs <= '0;
                r_stats <= '0;
            end else begin
                if (w_rd.pitch < r_lo) r_lo <= w_rd.pitch;
                if (w_rd.pitch > r_hi) r_hi <= w_rd.pitch;
                r_sum_p <= r_sum_p + (CW+7)'(w_rd.pitch);
                r_sum_d <= r_sum_d + (CW+24)'(w_rd.dur);
                r_sum_v <= r_sum_v + (CW+7)'(w_rd.vel);
                if (!w_inpc) r_insc <= 1'b0;
                if (w_overlap) r_mono <= 1'b0;
                if (w_eq) begin
                    r_stats <= r_stats + CW'(1);
                    r_reps  <= r_reps + CW'(1);
                end else begin
                    if (w_diff <= 7'd2) r_steps <= r_steps + CW'(1);
                    else                r_leaps <= r_leaps + CW'(1);
                    if (w_up) r_ups   <= r_ups + CW'(1);
                    else      r_downs <= r_downs + CW'(1);
                end
                if (w_half) begin
                    if (w_dn) r_fhr <= 1'b0;
                    if (w_up) r_fhf <= 1'b0;
                end else begin
                    if (w_up) r_shf <= 1'b0;
                    if (w_dn) r_shr <= 1'b0;
                end
            end
        end
    end

    // Melodic profile
    assign w_trans = r_count - CW'(1);
    always_comb begin
        if (r_count < CW'(2) || r_stats == w_trans) begin
            w_profile = P_STATIONARY;
        end else if ({1'b0, r_ups} > {r_downs, 1'b0} && r_ups >= r_stats) begin
            w_profile = P_ASCENDING;
        end else if ({1'b0, r_downs} > {r_ups, 1'b0} && r_downs >= r_stats) begin
            w_profile = P_DESCENDING;
        end else if (r_fhr && r_shf) begin
            w_profile = P_ARCH;
        end else if (r_fhf && r_shr) begin
            w_profile = P_VALLEY;
        end else begin
            w_profile = P_MIXED;
        end
    end

    // Divider operands per metric
    assign w_lo_sum = r_sum_p - (CW+7)'(r_count) * (CW+7)'(r_lo);
    always_comb begin
        w_num = '0;
        w_den = DEN_W'(w_trans);
        case (r_metric)
            M_STEP:    w_num = NUM_W'(r_steps) << 16;
            M_LEAP:    w_num = NUM_W'(r_leaps) << 16;
            M_REPEAT:  w_num = NUM_W'(r_reps) << 16;
            M_UP:      w_num = NUM_W'(r_ups) << 16;
            M_DOWN:    w_num = NUM_W'(r_downs) << 16;
            M_STAT:    w_num = NUM_W'(r_stats) << 16;
            M_AVG_P: begin
                w_num = NUM_W'(r_sum_p) << 16;
                w_den = DEN_W'(r_count);
            end
            M_AVG_D: begin
                w_num = NUM_W'(r_sum_d) << 8;
                w_den = DEN_W'(r_count);
            end
            M_AVG_V: begin
                w_num = NUM_W'(r_sum_v) << 16;
                w_den = DEN_W'(r_count);
            end
            M_DENSITY: begin
                w_num = NUM_W'(r_count) << 24;
                w_den = i_phrase_len;
            end
            M_POS: begin
                w_num = NUM_W'(w_lo_sum) << 16;
                w_den = DEN_W'(r_count) * DEN_W'(r_hi - r_lo);
            end
            default: w_num = '0;
        endcase
    end

    npst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Values that need no division
    always_comb begin
        case (r_metric)
            M_COUNT:   w_plain = 32'(r_count) << 16;
            M_LOW:     w_plain = 32'(r_lo) << 16;
            M_HIGH:    w_plain = 32'(r_hi) << 16;
            M_MONO:    w_plain = r_mono ? 32'h0001_0000 : 32'h0;
            M_INSCALE: w_plain = r_insc ? 32'h0001_0000 : 32'h0;
            M_PROFILE: w_plain = 32'(w_profile) << 16;
            default:   w_plain = w_quot;
        endcase
    end

    // Output register
    assign w_fire = r_out_valid & ~i_out_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_metric      <= r_metric;
            o_value       <= w_plain;
            o_overflow    <= r_drop;
            o_last_metric <= (r_metric == M_POS);
        end
    end

    assign o_out_valid = r_out_valid;

    // Status to the controller
    always_comb begin
        o_sts.full        = (r_count == CW'(MAX_NOTES));
        o_sts.pos_zero    = (r_pos == '0);
        o_sts.key_gt      = {w_rd.start, w_rd.pitch} > {r_new.start, r_new.pitch};
        o_sts.last        = r_last;
        o_sts.idx_last    = (CW'(r_idx) == w_trans);
        o_sts.metric_div  = (r_metric >= M_STEP);
        o_sts.metric_last = (r_metric == M_POS);
        o_sts.div_busy    = w_div_busy;
        o_sts.out_valid   = r_out_valid;
        o_sts.out_fire    = w_fire;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NOTES))
        else $error("note count beyond capacity");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("result loaded over a pending result");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_drop) |-> r_count == CW'(MAX_NOTES))
        else $error("note dropped while store not full");

endmodule

`default_nettype wire

[hdl/npst_ctrl.sv]
// ----------------------------------------------------------------------------
// npst_ctrl
// Controller: sequences insertion, scan, division and result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npst_ctrl import npst_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_last_note,
    output logic  o_in_stall,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid & ~o_in_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_sts.full) n_state = S_INS_RD;
                    else if (i_last_note) n_state = S_SC_RD;
                end
            end
            S_INS_RD: begin
                if (!i_sts.pos_zero) n_state = S_INS_CMP;
                else n_state = i_sts.last ? S_SC_RD : S_IDLE;
            end
            S_INS_CMP: begin
                if (i_sts.key_gt) n_state = S_INS_RD;
                else n_state = i_sts.last ? S_SC_RD : S_IDLE;
            end
            S_SC_RD:  n_state = S_SC_ACC;
            S_SC_ACC: n_state = i_sts.idx_last ? S_MET : S_SC_RD;
            S_MET:    n_state = i_sts.metric_div ? S_DIV : S_OUT;
            S_DIV: begin
                if (!i_sts.div_busy) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_fire) n_state = i_sts.metric_last ? S_IDLE : S_MET;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.accept = w_accept;
            S_INS_RD: begin
                o_cmd.place    = i_sts.pos_zero;
                o_cmd.ins_read = ~i_sts.pos_zero;
            end
            S_INS_CMP: begin
                o_cmd.shift = i_sts.key_gt;
                o_cmd.place = ~i_sts.key_gt;
            end
            S_SC_ACC: o_cmd.acc = 1'b1;
            S_MET: begin
                o_cmd.div_start = i_sts.metric_div;
                o_cmd.out_load  = ~i_sts.metric_div;
            end
            S_DIV: o_cmd.out_load = ~i_sts.div_busy;
            S_OUT: begin
                o_cmd.metric_inc = i_sts.out_fire & ~i_sts.metric_last;
                o_cmd.clear      = i_sts.out_fire & i_sts.metric_last;
            end
            default: o_cmd = '0;
        endcase
    end

    // Checks
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_busy |-> r_state == S_DIV)
        else $error("divider running outside divide state");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> i_sts.out_valid)
        else $error("waiting on a result that is not held");
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.out_valid |-> o_in_stall)
        else $error("input open while results pending");

endmodule

`default_nettype wire

[hdl/note_phrase_statistics_core.sv]
// Flow: each accepted note is placed by sorted insertion, reading and comparing
// stored notes from the back and shifting each later one up a slot.
// A closing note then starts a scan over the stored notes and 17 results; each
// ratio, average, density and position result waits on the serial divider.
// One item at a time; input stalls while any phrase work is pending.
// Reset (synchronous, active low) clears counts, flags, config and control.
// ----------------------------------------------------------------------------
// note_phrase_statistics_core
// Sorts a phrase's notes by start and pitch, then streams 17 metrics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module note_phrase_statistics_core import npst_pkg::*; #(
    parameter int MAX_NOTES = 256
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire [23:0]   i_start_beat,
    input  wire [23:0]   i_duration,
    input  wire [6:0]    i_pitch,
    input  wire [6:0]    i_velocity,
    input  wire          i_last_note,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output logic [4:0]   o_metric,
    output logic [31:0]  o_value,
    output logic         o_overflow,
    output logic         o_last_metric,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire          i_cfg_index,
    input  wire [23:0]   i_cfg_data
);

    logic [23:0] r_phrase_len;
    logic [11:0] r_scale_mask;
    t_cmd        w_cmd;
    t_sts        w_sts;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phrase_len <= '0;
            r_scale_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHRASE_LEN: r_phrase_len <= i_cfg_data;
                CFG_SCALE_MASK: r_scale_mask <= i_cfg_data[11:0];
                default:        r_phrase_len <= r_phrase_len;
            endcase
        end
    end

    npst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_note (i_last_note),
        .o_in_stall  (o_in_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    npst_dp #(.MAX_NOTES(MAX_NOTES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_start_beat  (i_start_beat),
        .i_duration    (i_duration),
        .i_pitch       (i_pitch),
        .i_velocity    (i_velocity),
        .i_last_note   (i_last_note),
        .i_phrase_len  (r_phrase_len),
        .i_scale_mask  (r_scale_mask),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_metric      (o_metric),
        .o_value       (o_value),
        .o_overflow    (o_overflow),
        .o_last_metric (o_last_metric)
    );

endmodule

`default_nettype wire
